>>> src/lwbc_pkg.sv
// Shared constants and types for the LRU write-back block cache controller.
// No dependencies; compiled first.
`default_nettype none

package lwbc_pkg;

   localparam int FUNC_W   = 2;
   localparam int SECTOR_W = 32;
   localparam int SLOT_W   = 6;
   localparam int COUNT_W  = 32;

   typedef logic [FUNC_W-1:0] func_type;

   localparam func_type FUNC_READ  = 2'd0;
   localparam func_type FUNC_WRITE = 2'd1;
   localparam func_type FUNC_FLUSH = 2'd2;

endpackage

`default_nettype wire

>>> src/lwbc_if.sv
// Request and response channel interfaces (valid/ready plus payload).
// Depends on lwbc_pkg.
`default_nettype none

interface lwbc_req_if;
   import lwbc_pkg::*;

   logic                valid;
   logic                ready;
   func_type            func;
   logic [SECTOR_W-1:0] sector;

   modport source (output valid, func, sector, input ready);
   modport sink   (input valid, func, sector, output ready);
endinterface

interface lwbc_rsp_if;
   import lwbc_pkg::*;

   logic                valid;
   logic                ready;
   logic                hit;
   logic [SLOT_W-1:0]   slot;
   logic                evict_valid;
   logic [SECTOR_W-1:0] evicted_sector;
   logic                writeback;
   logic [COUNT_W-1:0]  miss_count;
   logic                last;

   modport source (output valid, hit, slot, evict_valid, evicted_sector, writeback,
                   miss_count, last, input ready);
   modport sink   (input valid, hit, slot, evict_valid, evicted_sector, writeback,
                   miss_count, last, output ready);
endinterface

`default_nettype wire

>>> src/lwbc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module lwbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/lru_writeback_block_cache.sv
// Access: a tag scan over every entry, then a rank-ageing sweep, then an install step;
// the response word is registered after the install and held until it is taken.
// Flush: a sweep sorting held slots by rank, then one result word per held slot.
// One request at a time; the one-entry-per-cycle sweeps over the entry RAM set the rate.
// Synchronous reset clears valid bits, held count and miss count at once; no
// clearing pass, tag contents stay undefined until written.
`default_nettype none

module lru_writeback_block_cache #(
   parameter int ENTRIES     = 64,
   parameter int SECTOR_BITS = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   lwbc_req_if.sink   req_ch,
   lwbc_rsp_if.source rsp_ch
);
   import lwbc_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = IDX_W + 1;
   localparam int ENT_W = SECTOR_BITS + 1 + IDX_W;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(ENTRIES);
   localparam logic [IDX_W-1:0] OLDEST    = IDX_W'(ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_AGE, ST_INSTALL, ST_SORT, ST_FREAD, ST_FWAIT, ST_RESP
   } state_type;

   // control
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     addr_d_ff, addr_d_in;
   logic [ENTRIES-1:0]   valid_ff, valid_in;
   logic [CNT_W-1:0]     held_ff, held_in;
   logic [COUNT_W-1:0]   misses_ff, misses_in;
   logic                 hit_ff, hit_in;
   logic                 free_fnd_ff, free_fnd_in;
   logic [IDX_W-1:0]     rank_ptr_ff, rank_ptr_in;
   logic                 more_ff, more_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload
   logic                   wr_ff, wr_in;
   logic [SECTOR_BITS-1:0] sec_ff, sec_in;
   logic [IDX_W-1:0]       tgt_slot_ff, tgt_slot_in;
   logic                   tgt_dirty_ff, tgt_dirty_in;
   logic [IDX_W-1:0]       tgt_rank_ff, tgt_rank_in;
   logic [IDX_W-1:0]       free_slot_ff, free_slot_in;
   logic [IDX_W-1:0]       vic_slot_ff, vic_slot_in;
   logic [SECTOR_BITS-1:0] vic_tag_ff, vic_tag_in;
   logic                   vic_dirty_ff, vic_dirty_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;
   logic                   rsp_ev_ff, rsp_ev_in;
   logic [SECTOR_W-1:0]    rsp_esec_ff, rsp_esec_in;
   logic                   rsp_wb_ff, rsp_wb_in;
   logic [COUNT_W-1:0]     rsp_miss_ff, rsp_miss_in;
   logic                   rsp_last_ff, rsp_last_in;

   // RAM ports
   logic             ent_we, ord_we;
   logic [IDX_W-1:0] ent_wa, ent_ra, ord_wa, ord_ra;
   logic [ENT_W-1:0] ent_wd, ent_rd, ord_wd, ord_rd;

   // decoded entry / order words
   logic [SECTOR_BITS-1:0] e_tag, o_tag;
   logic                   e_dirty, o_dirty;
   logic [IDX_W-1:0]       e_rank, o_slot;
   logic                   e_valid, issue, sweep_done;
   logic [IDX_W-1:0]       slot_sel, limit_sel;
   logic                   age_all, evict, is_last;

   assign e_tag   = ent_rd[ENT_W-1 -: SECTOR_BITS];
   assign e_dirty = ent_rd[IDX_W];
   assign e_rank  = ent_rd[IDX_W-1:0];
   assign o_tag   = ord_rd[ENT_W-1 -: SECTOR_BITS];
   assign o_dirty = ord_rd[IDX_W];
   assign o_slot  = ord_rd[IDX_W-1:0];
   assign e_valid = valid_ff[addr_d_ff];

   assign issue      = idx_ff < DEPTH_CNT;
   assign sweep_done = !issue && !pend_ff;

   assign slot_sel  = hit_ff ? tgt_slot_ff : (free_fnd_ff ? free_slot_ff : vic_slot_ff);
   assign limit_sel = hit_ff ? tgt_rank_ff : OLDEST;
   assign age_all   = !hit_ff && free_fnd_ff;
   assign evict     = !hit_ff && !free_fnd_ff;
   assign is_last   = ({1'b0, rank_ptr_ff} + CNT_W'(1)) == held_ff;

   lwbc_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_wa),
      .wr_data (ent_wd),
      .rd_addr (ent_ra),
      .rd_data (ent_rd)
   );

   // rank-ordered copy of held slots, built at flush
   lwbc_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_order_ram (
      .clock   (clock),
      .wr_en   (ord_we),
      .wr_addr (ord_wa),
      .wr_data (ord_wd),
      .rd_addr (ord_ra),
      .rd_data (ord_rd)
   );

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      addr_d_in    = idx_ff[IDX_W-1:0];
      valid_in     = valid_ff;
      held_in      = held_ff;
      misses_in    = misses_ff;
      hit_in       = hit_ff;
      free_fnd_in  = free_fnd_ff;
      rank_ptr_in  = rank_ptr_ff;
      more_in      = more_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_in        = wr_ff;
      sec_in       = sec_ff;
      tgt_slot_in  = tgt_slot_ff;
      tgt_dirty_in = tgt_dirty_ff;
      tgt_rank_in  = tgt_rank_ff;
      free_slot_in = free_slot_ff;
      vic_slot_in  = vic_slot_ff;
      vic_tag_in   = vic_tag_ff;
      vic_dirty_in = vic_dirty_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_esec_in  = rsp_esec_ff;
      rsp_wb_in    = rsp_wb_ff;
      rsp_miss_in  = rsp_miss_ff;
      rsp_last_in  = rsp_last_ff;

      ent_we = 1'b0;
      ent_wa = addr_d_ff;
      ent_wd = {e_tag, e_dirty, e_rank + IDX_W'(1)};
      ent_ra = idx_ff[IDX_W-1:0];
      ord_we = 1'b0;
      ord_wa = e_rank;
      ord_wd = {e_tag, e_dirty, addr_d_ff};
      ord_ra = rank_ptr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               sec_in      = req_ch.sector[SECTOR_BITS-1:0];
               wr_in       = req_ch.func == FUNC_WRITE;
               idx_in      = '0;
               hit_in      = 1'b0;
               free_fnd_in = 1'b0;
               more_in     = 1'b0;
               // idle word for an empty flush or an unused code
               rsp_hit_in  = 1'b0;
               rsp_slot_in = '0;
               rsp_ev_in   = 1'b0;
               rsp_esec_in = '0;
               rsp_wb_in   = 1'b0;
               rsp_miss_in = misses_ff;
               rsp_last_in = 1'b1;
               priority if (req_ch.func == FUNC_FLUSH) begin
                  if (held_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_RESP;
                  end else begin
                     state_in = ST_SORT;
                  end
               end else if (req_ch.func == FUNC_READ || req_ch.func == FUNC_WRITE) begin
                  state_in = ST_SCAN;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_RESP;
               end
            end
         end

         ST_SCAN: begin
            pend_in = issue;
            if (issue) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               if (e_valid && e_tag == sec_ff && !hit_ff) begin
                  hit_in       = 1'b1;
                  tgt_slot_in  = addr_d_ff;
                  tgt_dirty_in = e_dirty;
                  tgt_rank_in  = e_rank;
               end
               if (!e_valid && !free_fnd_ff) begin
                  free_fnd_in  = 1'b1;
                  free_slot_in = addr_d_ff;
               end
               if (e_valid && e_rank == OLDEST) begin
                  vic_slot_in  = addr_d_ff;
                  vic_tag_in   = e_tag;
                  vic_dirty_in = e_dirty;
               end
            end
            if (sweep_done) begin
               idx_in   = '0;
               state_in = ST_AGE;
            end
         end

         ST_AGE: begin
            pend_in = issue;
            if (issue) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            // target slot is never aged: its rank equals the limit, or it is free
            if (pend_ff && e_valid && (age_all || e_rank < limit_sel)) begin
               ent_we = 1'b1;
            end
            if (sweep_done) begin
               state_in = ST_INSTALL;
            end
         end

         ST_INSTALL: begin
            ent_we = 1'b1;
            ent_wa = slot_sel;
            ent_wd = {sec_ff, hit_ff ? (tgt_dirty_ff | wr_ff) : wr_ff, IDX_W'(0)};
            valid_in[slot_sel] = 1'b1;
            if (age_all) begin
               held_in = held_ff + CNT_W'(1);
            end
            if (!hit_ff) begin
               misses_in = misses_ff + COUNT_W'(1);
            end
            rsp_hit_in   = hit_ff;
            rsp_slot_in  = SLOT_W'(slot_sel);
            rsp_ev_in    = evict;
            rsp_esec_in  = evict ? SECTOR_W'(vic_tag_ff) : '0;
            rsp_wb_in    = evict && vic_dirty_ff;
            rsp_miss_in  = misses_in;
            rsp_last_in  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_RESP;
         end

         ST_SORT: begin
            pend_in = issue;
            if (issue) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            if (pend_ff && e_valid) begin
               ord_we = 1'b1;
            end
            if (sweep_done) begin
               rank_ptr_in = '0;
               state_in    = ST_FREAD;
            end
         end

         ST_FREAD: begin
            state_in = ST_FWAIT;
         end

         ST_FWAIT: begin
            rsp_hit_in   = 1'b0;
            rsp_slot_in  = SLOT_W'(o_slot);
            rsp_ev_in    = 1'b1;
            rsp_esec_in  = SECTOR_W'(o_tag);
            rsp_wb_in    = o_dirty;
            rsp_miss_in  = misses_ff;
            rsp_last_in  = is_last;
            rsp_valid_in = 1'b1;
            more_in      = !is_last;
            if (is_last) begin
               valid_in = '0;
               held_in  = '0;
            end
            state_in = ST_RESP;
         end

         ST_RESP: begin
            if (rsp_ch.ready) begin
               rsp_valid_in = 1'b0;
               if (more_ff) begin
                  rank_ptr_in = rank_ptr_ff + IDX_W'(1);
                  state_in    = ST_FREAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         valid_ff     <= '0;
         held_ff      <= '0;
         misses_ff    <= '0;
         hit_ff       <= 1'b0;
         free_fnd_ff  <= 1'b0;
         rank_ptr_ff  <= '0;
         more_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         valid_ff     <= valid_in;
         held_ff      <= held_in;
         misses_ff    <= misses_in;
         hit_ff       <= hit_in;
         free_fnd_ff  <= free_fnd_in;
         rank_ptr_ff  <= rank_ptr_in;
         more_ff      <= more_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_d_ff    <= addr_d_in;
      wr_ff        <= wr_in;
      sec_ff       <= sec_in;
      tgt_slot_ff  <= tgt_slot_in;
      tgt_dirty_ff <= tgt_dirty_in;
      tgt_rank_ff  <= tgt_rank_in;
      free_slot_ff <= free_slot_in;
      vic_slot_ff  <= vic_slot_in;
      vic_tag_ff   <= vic_tag_in;
      vic_dirty_ff <= vic_dirty_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_esec_ff  <= rsp_esec_in;
      rsp_wb_ff    <= rsp_wb_in;
      rsp_miss_ff  <= rsp_miss_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_ch.ready          = state_ff == ST_IDLE;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.hit            = rsp_hit_ff;
   assign rsp_ch.slot           = rsp_slot_ff;
   assign rsp_ch.evict_valid    = rsp_ev_ff;
   assign rsp_ch.evicted_sector = rsp_esec_ff;
   assign rsp_ch.writeback      = rsp_wb_ff;
   assign rsp_ch.miss_count     = rsp_miss_ff;
   assign rsp_ch.last           = rsp_last_ff;

   // a request is never taken while a word is still on offer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("request accepted with response pending");

   a_held_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(held_ff))
      else $error("held count out of step with valid bits");

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= DEPTH_CNT)
      else $error("held count beyond capacity");

   a_install_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INSTALL |=> valid_ff[$past(slot_sel)])
      else $error("installed slot not marked valid");

   a_miss_source: assert property (@(posedge clock) disable iff (reset)
      misses_ff != $past(misses_ff) |-> $past(state_ff) == ST_INSTALL)
      else $error("miss count moved outside install");

endmodule

`default_nettype wire
